// ===== rtl/dpr_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// dpr_pkg: constants shared by the delay phase rotator
// Fixed-point formats, the turn scale factor and the arctangent table.
// ----------------------------------------------------------------------------
package dpr_pkg;

   localparam int DELAY_W   = 40;
   localparam int DIFF_W    = DELAY_W + 1;
   localparam int MAG_W     = DELAY_W;
   localparam int FREQ_W    = 26;

   // round(256000 * 2^44 / c), c = 299792458 m/s
   localparam int TURN_K_W  = 34;
   localparam logic [TURN_K_W-1:0] TURN_K = 34'd15022391348;
   localparam int FK_W      = FREQ_W + TURN_K_W;

   // 40 x 60 product split into four 20 x 30 partial products
   localparam int MAG_LO_W  = 20;
   localparam int FK_LO_W   = 30;
   localparam int PART_W    = MAG_LO_W + FK_LO_W;
   localparam int PAIR_W    = PART_W + MAG_LO_W + 1;
   localparam int PROD_W    = MAG_W + FK_W;
   localparam int TURN_SHIFT = 44;
   localparam int TMAG_W    = PROD_W - TURN_SHIFT;

   // 92160 = 45 * 2^11, so the phase in 1/256 degree = (tmag * 45) >> 21
   localparam int DEG_MUL_W = 6;
   localparam logic [DEG_MUL_W-1:0] DEG_MUL = 6'd45;
   localparam int DEG_PROD_W = TMAG_W + DEG_MUL_W;
   localparam int DEG_SHIFT = 21;
   localparam int PMAG_W    = DEG_PROD_W - DEG_SHIFT;

   localparam int PHASE_W   = 32;
   localparam logic [PMAG_W-1:0]  PMAG_POS_LIMIT = 41'h0_7FFF_FFFF;
   localparam logic [PMAG_W-1:0]  PMAG_NEG_LIMIT = 41'h0_8000_0000;
   localparam logic [PHASE_W-1:0] PHASE_MAX      = 32'h7FFF_FFFF;
   localparam logic [PHASE_W-1:0] PHASE_MIN      = 32'h8000_0000;

   // cordic gain compensation, Q24
   localparam int GAIN_W    = 24;
   localparam logic [GAIN_W-1:0] GAIN = 24'd10188014;
   localparam int ROUND_SHIFT = 24;
   localparam logic [ROUND_SHIFT-1:0] ROUND_HALF = 24'h80_0000;

   // angles in units of 2^-32 turn
   localparam int ANGLE_W   = 32;
   localparam int ARC_LEN   = 24;
   localparam logic [ANGLE_W-1:0] ARC_TABLE [ARC_LEN] = '{
      32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
      32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
      32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
      32'd166886,    32'd83443,     32'd41722,     32'd20861,
      32'd10430,     32'd5215,      32'd2608,      32'd1304,
      32'd652,       32'd326,       32'd163,       32'd81
   };

endpackage
`default_nettype wire

// ===== rtl/delay_phase_rotator.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// delay_phase_rotator: fringe rotation of one visibility sample
// Baseline phase from two antenna delays and a sky frequency, reported in
// degrees and applied to the sample by a pipelined cordic rotator.
// ----------------------------------------------------------------------------
// The block takes one beat per clock cycle unless stalled by rsp_ready, and
// gives one result beat for each, in order. A request passes through seven
// stages that build the phase (delay difference and frequency scale,
// magnitude, a 40 x 60 bit turn product done as four 20 x 30 partial
// products summed over two stages, the degree scale and the quadrant fold),
// then one cordic micro-rotation per stage, then rounding and saturation
// into the output register. Every stage carries its own valid bit and a
// stage moves on whenever the stage after it is empty or moving, so gaps in
// the pipeline are filled while a result waits on rsp_ready. The phase is in
// units of 1/256 degree, truncated toward zero and saturated to 32 bits; the
// rotated parts are rounded and saturated to SAMPLE_BITS.
// ----------------------------------------------------------------------------
module delay_phase_rotator #(
   parameter int SAMPLE_BITS   = 18,
   parameter int CORDIC_STAGES = 16
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 req_valid,
   output logic                                      req_ready,
   input  wire logic signed [dpr_pkg::DELAY_W-1:0]   req_first_delay,
   input  wire logic signed [dpr_pkg::DELAY_W-1:0]   req_second_delay,
   input  wire logic        [dpr_pkg::FREQ_W-1:0]    req_channel_freq,
   input  wire logic signed [SAMPLE_BITS-1:0]        req_vis_real,
   input  wire logic signed [SAMPLE_BITS-1:0]        req_vis_imag,
   output logic                                      rsp_valid,
   input  wire logic                                 rsp_ready,
   output logic signed [dpr_pkg::PHASE_W-1:0]        rsp_phase_degrees,
   output logic signed [SAMPLE_BITS-1:0]             rsp_out_real,
   output logic signed [SAMPLE_BITS-1:0]             rsp_out_imag
);

   localparam int NUM_ROT = (CORDIC_STAGES < dpr_pkg::ARC_LEN) ?
                            CORDIC_STAGES : dpr_pkg::ARC_LEN;
   localparam int FRONT   = 7;
   localparam int NSTG    = FRONT + NUM_ROT + 1;
   localparam int GX_W    = SAMPLE_BITS + dpr_pkg::GAIN_W + 1;
   localparam int XW      = SAMPLE_BITS + 27;
   localparam int RW      = XW - dpr_pkg::ROUND_SHIFT;
   localparam int AW      = dpr_pkg::ANGLE_W;
   localparam int PW      = dpr_pkg::PHASE_W;

   // stage control
   logic [FRONT-1:0]   front_valid_ff;
   logic [FRONT-1:0]   front_valid_in;
   logic [NUM_ROT-1:0] rot_valid;
   logic [NUM_ROT-1:0] rot_src_valid;
   logic               rsp_valid_ff;
   logic [NSTG-1:0]    stage_valid;
   logic [NSTG-1:0]    stage_en;

   // stage 1: delay difference, frequency scale, gain
   logic        [dpr_pkg::DIFF_W-1:0] s1_diff_ff, s1_diff_in;
   logic        [dpr_pkg::FK_W-1:0]   s1_fk_ff, s1_fk_in;
   logic signed [GX_W-1:0]            s1_xg_ff, s1_xg_in;
   logic signed [GX_W-1:0]            s1_yg_ff, s1_yg_in;

   // stage 2: magnitude and sign
   logic                              s2_neg_ff;
   logic        [dpr_pkg::MAG_W-1:0]  s2_mag_ff, s2_mag_in;
   logic        [dpr_pkg::DIFF_W-1:0] s2_abs;
   logic        [dpr_pkg::FK_W-1:0]   s2_fk_ff;
   logic signed [GX_W-1:0]            s2_xg_ff;
   logic signed [GX_W-1:0]            s2_yg_ff;

   // stage 3: partial products
   logic                              s3_neg_ff;
   logic        [dpr_pkg::PART_W-1:0] s3_ll_ff, s3_hl_ff, s3_lh_ff, s3_hh_ff;
   logic        [dpr_pkg::PART_W-1:0] s3_ll_in, s3_hl_in, s3_lh_in, s3_hh_in;
   logic signed [GX_W-1:0]            s3_xg_ff;
   logic signed [GX_W-1:0]            s3_yg_ff;

   // stage 4: partial sums
   logic                              s4_neg_ff;
   logic        [dpr_pkg::PAIR_W-1:0] s4_lo_ff, s4_lo_in;
   logic        [dpr_pkg::PAIR_W-1:0] s4_hi_ff, s4_hi_in;
   logic signed [GX_W-1:0]            s4_xg_ff;
   logic signed [GX_W-1:0]            s4_yg_ff;

   // stage 5: turn magnitude
   logic                              s5_neg_ff;
   logic        [dpr_pkg::PROD_W-1:0] s5_prod;
   logic        [dpr_pkg::TMAG_W-1:0] s5_tmag_ff;
   logic signed [GX_W-1:0]            s5_xg_ff;
   logic signed [GX_W-1:0]            s5_yg_ff;

   // stage 6: degree magnitude and rotation angle
   logic                                  s6_neg_ff;
   logic        [dpr_pkg::DEG_PROD_W-1:0] s6_deg_prod;
   logic        [dpr_pkg::PMAG_W-1:0]     s6_pmag_ff;
   logic        [AW-1:0]                  s6_angle_ff, s6_angle_in;
   logic signed [GX_W-1:0]                s6_xg_ff;
   logic signed [GX_W-1:0]                s6_yg_ff;

   // stage 7: quadrant fold and phase saturation
   logic                 s7_fold;
   logic signed [XW-1:0] s7_x_ext, s7_y_ext;
   logic signed [XW-1:0] s7_x_ff, s7_x_in;
   logic signed [XW-1:0] s7_y_ff, s7_y_in;
   logic        [AW-1:0] s7_z_ff, s7_z_in;
   logic        [PW-1:0] s7_phase_ff, s7_phase_in;

   // cordic chain, entry 0 is stage 7
   logic signed [XW-1:0] rot_x [NUM_ROT+1];
   logic signed [XW-1:0] rot_y [NUM_ROT+1];
   logic        [AW-1:0] rot_z [NUM_ROT+1];
   logic        [PW-1:0] rot_phase [NUM_ROT+1];

   // output stage
   logic signed [XW-1:0]          out_x_rnd, out_y_rnd;
   logic        [PW-1:0]          rsp_phase_degrees_ff;
   logic signed [SAMPLE_BITS-1:0] rsp_out_real_ff, rsp_out_real_in;
   logic signed [SAMPLE_BITS-1:0] rsp_out_imag_ff, rsp_out_imag_in;

   function automatic logic [SAMPLE_BITS-1:0] sat_sample(input logic [RW-1:0] r);
      logic [RW-SAMPLE_BITS:0] top;
      top = r[RW-1:SAMPLE_BITS-1];
      if ((&top) || !(|top)) begin
         return r[SAMPLE_BITS-1:0];
      end else if (r[RW-1]) begin
         return {1'b1, {(SAMPLE_BITS-1){1'b0}}};
      end else begin
         return {1'b0, {(SAMPLE_BITS-1){1'b1}}};
      end
   endfunction

   // ------------------------------------------------------------------
   // flow control: a stage moves on rsp_ready or when it or any later stage has a hole
   // ------------------------------------------------------------------
   assign stage_valid = {rsp_valid_ff, rot_valid, front_valid_ff};

   for (genvar k = 0; k < NSTG; k++) begin : g_en
      assign stage_en[k] = rsp_ready || !(&stage_valid[NSTG-1:k]);
   end

   assign req_ready      = stage_en[0];
   assign front_valid_in = {front_valid_ff[FRONT-2:0], req_valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         front_valid_ff <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         for (int k = 0; k < FRONT; k++) begin
            if (stage_en[k]) begin
               front_valid_ff[k] <= front_valid_in[k];
            end
         end
         if (stage_en[NSTG-1]) begin
            rsp_valid_ff <= rot_valid[NUM_ROT-1];
         end
      end
   end

   // ------------------------------------------------------------------
   // phase path
   // ------------------------------------------------------------------
   always_comb begin
      s1_diff_in = {req_first_delay[dpr_pkg::DELAY_W-1], req_first_delay}
                 - {req_second_delay[dpr_pkg::DELAY_W-1], req_second_delay};
      s1_fk_in   = dpr_pkg::FK_W'(req_channel_freq) * dpr_pkg::FK_W'(dpr_pkg::TURN_K);
      s1_xg_in   = req_vis_real * $signed({1'b0, dpr_pkg::GAIN});
      s1_yg_in   = req_vis_imag * $signed({1'b0, dpr_pkg::GAIN});
   end

   assign s2_abs    = s1_diff_ff[dpr_pkg::DIFF_W-1] ? (dpr_pkg::DIFF_W'(0) - s1_diff_ff)
                                                    : s1_diff_ff;
   assign s2_mag_in = s2_abs[dpr_pkg::MAG_W-1:0];

   always_comb begin
      s3_ll_in = dpr_pkg::PART_W'(s2_mag_ff[dpr_pkg::MAG_LO_W-1:0])
               * dpr_pkg::PART_W'(s2_fk_ff[dpr_pkg::FK_LO_W-1:0]);
      s3_hl_in = dpr_pkg::PART_W'(s2_mag_ff[dpr_pkg::MAG_W-1:dpr_pkg::MAG_LO_W])
               * dpr_pkg::PART_W'(s2_fk_ff[dpr_pkg::FK_LO_W-1:0]);
      s3_lh_in = dpr_pkg::PART_W'(s2_mag_ff[dpr_pkg::MAG_LO_W-1:0])
               * dpr_pkg::PART_W'(s2_fk_ff[dpr_pkg::FK_W-1:dpr_pkg::FK_LO_W]);
      s3_hh_in = dpr_pkg::PART_W'(s2_mag_ff[dpr_pkg::MAG_W-1:dpr_pkg::MAG_LO_W])
               * dpr_pkg::PART_W'(s2_fk_ff[dpr_pkg::FK_W-1:dpr_pkg::FK_LO_W]);
   end

   always_comb begin
      s4_lo_in = dpr_pkg::PAIR_W'(s3_ll_ff)
               + (dpr_pkg::PAIR_W'(s3_hl_ff) << dpr_pkg::MAG_LO_W);
      s4_hi_in = dpr_pkg::PAIR_W'(s3_lh_ff)
               + (dpr_pkg::PAIR_W'(s3_hh_ff) << dpr_pkg::MAG_LO_W);
   end

   assign s5_prod = dpr_pkg::PROD_W'(s4_lo_ff)
                  + (dpr_pkg::PROD_W'(s4_hi_ff) << dpr_pkg::FK_LO_W);

   assign s6_deg_prod = dpr_pkg::DEG_PROD_W'(s5_tmag_ff)
                      * dpr_pkg::DEG_PROD_W'(dpr_pkg::DEG_MUL);
   // rotation angle is minus the signed phase, modulo one turn
   assign s6_angle_in = s5_neg_ff ? s5_tmag_ff[AW-1:0] : (AW'(0) - s5_tmag_ff[AW-1:0]);

   // angles in the left half-plane: negate the vector, take half a turn off
   assign s7_fold  = s6_angle_ff[AW-1] ^ s6_angle_ff[AW-2];
   assign s7_x_ext = XW'(s6_xg_ff);
   assign s7_y_ext = XW'(s6_yg_ff);

   always_comb begin
      s7_x_in = s7_fold ? -s7_x_ext : s7_x_ext;
      s7_y_in = s7_fold ? -s7_y_ext : s7_y_ext;
      s7_z_in = {s6_angle_ff[AW-1] ^ s7_fold, s6_angle_ff[AW-2:0]};
      if (s6_neg_ff) begin
         s7_phase_in = (s6_pmag_ff > dpr_pkg::PMAG_NEG_LIMIT) ? dpr_pkg::PHASE_MIN
                                                              : (PW'(0) - s6_pmag_ff[PW-1:0]);
      end else begin
         s7_phase_in = (s6_pmag_ff > dpr_pkg::PMAG_POS_LIMIT) ? dpr_pkg::PHASE_MAX
                                                              : s6_pmag_ff[PW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (stage_en[0]) begin
         s1_diff_ff <= s1_diff_in;
         s1_fk_ff   <= s1_fk_in;
         s1_xg_ff   <= s1_xg_in;
         s1_yg_ff   <= s1_yg_in;
      end
      if (stage_en[1]) begin
         s2_neg_ff <= s1_diff_ff[dpr_pkg::DIFF_W-1];
         s2_mag_ff <= s2_mag_in;
         s2_fk_ff  <= s1_fk_ff;
         s2_xg_ff  <= s1_xg_ff;
         s2_yg_ff  <= s1_yg_ff;
      end
      if (stage_en[2]) begin
         s3_neg_ff <= s2_neg_ff;
         s3_ll_ff  <= s3_ll_in;
         s3_hl_ff  <= s3_hl_in;
         s3_lh_ff  <= s3_lh_in;
         s3_hh_ff  <= s3_hh_in;
         s3_xg_ff  <= s2_xg_ff;
         s3_yg_ff  <= s2_yg_ff;
      end
      if (stage_en[3]) begin
         s4_neg_ff <= s3_neg_ff;
         s4_lo_ff  <= s4_lo_in;
         s4_hi_ff  <= s4_hi_in;
         s4_xg_ff  <= s3_xg_ff;
         s4_yg_ff  <= s3_yg_ff;
      end
      if (stage_en[4]) begin
         s5_neg_ff  <= s4_neg_ff;
         s5_tmag_ff <= s5_prod[dpr_pkg::PROD_W-1:dpr_pkg::TURN_SHIFT];
         s5_xg_ff   <= s4_xg_ff;
         s5_yg_ff   <= s4_yg_ff;
      end
      if (stage_en[5]) begin
         s6_neg_ff   <= s5_neg_ff;
         s6_pmag_ff  <= s6_deg_prod[dpr_pkg::DEG_PROD_W-1:dpr_pkg::DEG_SHIFT];
         s6_angle_ff <= s6_angle_in;
         s6_xg_ff    <= s5_xg_ff;
         s6_yg_ff    <= s5_yg_ff;
      end
      if (stage_en[6]) begin
         s7_x_ff     <= s7_x_in;
         s7_y_ff     <= s7_y_in;
         s7_z_ff     <= s7_z_in;
         s7_phase_ff <= s7_phase_in;
      end
   end

   // ------------------------------------------------------------------
   // cordic rotator, one micro-rotation per stage
   // ------------------------------------------------------------------
   assign rot_x[0]     = s7_x_ff;
   assign rot_y[0]     = s7_y_ff;
   assign rot_z[0]     = s7_z_ff;
   assign rot_phase[0] = s7_phase_ff;

   if (NUM_ROT > 1) begin : g_src_chain
      assign rot_src_valid = {rot_valid[NUM_ROT-2:0], front_valid_ff[FRONT-1]};
   end else begin : g_src_single
      assign rot_src_valid = front_valid_ff[FRONT-1];
   end

   for (genvar k = 0; k < NUM_ROT; k++) begin : g_rot
      dpr_rotate #(
         .WIDTH (XW),
         .SHIFT (k),
         .ANGLE (dpr_pkg::ARC_TABLE[k])
      ) u_rotate (
         .clock     (clock),
         .reset     (reset),
         .advance   (stage_en[FRONT+k]),
         .src_valid (rot_src_valid[k]),
         .src_x     (rot_x[k]),
         .src_y     (rot_y[k]),
         .src_z     (rot_z[k]),
         .src_phase (rot_phase[k]),
         .rot_valid (rot_valid[k]),
         .rot_x     (rot_x[k+1]),
         .rot_y     (rot_y[k+1]),
         .rot_z     (rot_z[k+1]),
         .rot_phase (rot_phase[k+1])
      );
   end

   // ------------------------------------------------------------------
   // rounding, saturation and output register
   // ------------------------------------------------------------------
   assign out_x_rnd = rot_x[NUM_ROT] + $signed(XW'(dpr_pkg::ROUND_HALF));
   assign out_y_rnd = rot_y[NUM_ROT] + $signed(XW'(dpr_pkg::ROUND_HALF));
   assign rsp_out_real_in = sat_sample(out_x_rnd[XW-1:dpr_pkg::ROUND_SHIFT]);
   assign rsp_out_imag_in = sat_sample(out_y_rnd[XW-1:dpr_pkg::ROUND_SHIFT]);

   always_ff @(posedge clock) begin
      if (stage_en[NSTG-1]) begin
         rsp_phase_degrees_ff <= rot_phase[NUM_ROT];
         rsp_out_real_ff      <= rsp_out_real_in;
         rsp_out_imag_ff      <= rsp_out_imag_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_phase_degrees = rsp_phase_degrees_ff;
   assign rsp_out_real      = rsp_out_real_ff;
   assign rsp_out_imag      = rsp_out_imag_ff;

   // ------------------------------------------------------------------
   // assertions
   // ------------------------------------------------------------------
   // a valid beat in the first stage stays valid while stage two stalls
   a_first_stage_holds: assert property (@(posedge clock) disable iff (reset)
      front_valid_ff[0] && !stage_en[1] |=> front_valid_ff[0])
      else $error("first stage beat lost under stall");

   // after the fold the angle lies within a quarter turn either way
   a_fold_range: assert property (@(posedge clock) disable iff (reset)
      front_valid_ff[FRONT-1] |-> (rot_z[0][AW-1] == rot_z[0][AW-2]))
      else $error("folded angle outside quarter turn");

   // residual angle has converged below an eighth of a turn
   a_residual_small: assert property (@(posedge clock) disable iff (reset)
      rot_valid[NUM_ROT-1] |->
         (rot_z[NUM_ROT][AW-1:AW-3] == 3'b000 || rot_z[NUM_ROT][AW-1:AW-3] == 3'b111))
      else $error("cordic residual angle too large");

endmodule
`default_nettype wire

// ===== rtl/dpr_rotate.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// dpr_rotate: one cordic micro-rotation stage
// Rotates by the stage angle in the direction given by the residual angle,
// holding its beat while the following stage is stalled.
// ----------------------------------------------------------------------------
module dpr_rotate #(
   parameter int WIDTH = 45,
   parameter int SHIFT = 0,
   parameter logic [dpr_pkg::ANGLE_W-1:0] ANGLE = 32'd0
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                advance,
   input  wire logic                                src_valid,
   input  wire logic signed [WIDTH-1:0]             src_x,
   input  wire logic signed [WIDTH-1:0]             src_y,
   input  wire logic        [dpr_pkg::ANGLE_W-1:0]  src_z,
   input  wire logic        [dpr_pkg::PHASE_W-1:0]  src_phase,
   output logic                                     rot_valid,
   output logic signed [WIDTH-1:0]                  rot_x,
   output logic signed [WIDTH-1:0]                  rot_y,
   output logic        [dpr_pkg::ANGLE_W-1:0]       rot_z,
   output logic        [dpr_pkg::PHASE_W-1:0]       rot_phase
);

   logic                               valid_ff;
   logic signed [WIDTH-1:0]            x_ff, x_in;
   logic signed [WIDTH-1:0]            y_ff, y_in;
   logic        [dpr_pkg::ANGLE_W-1:0] z_ff, z_in;
   logic        [dpr_pkg::PHASE_W-1:0] phase_ff;
   logic signed [WIDTH-1:0]            x_shr;
   logic signed [WIDTH-1:0]            y_shr;

   assign x_shr = src_x >>> SHIFT;
   assign y_shr = src_y >>> SHIFT;

   always_comb begin
      // non-negative residual turns counter-clockwise
      if (!src_z[dpr_pkg::ANGLE_W-1]) begin
         x_in = src_x - y_shr;
         y_in = src_y + x_shr;
         z_in = src_z - ANGLE;
      end else begin
         x_in = src_x + y_shr;
         y_in = src_y - x_shr;
         z_in = src_z + ANGLE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= src_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         x_ff     <= x_in;
         y_ff     <= y_in;
         z_ff     <= z_in;
         phase_ff <= src_phase;
      end
   end

   assign rot_valid = valid_ff;
   assign rot_x     = x_ff;
   assign rot_y     = y_ff;
   assign rot_z     = z_ff;
   assign rot_phase = phase_ff;

endmodule
`default_nettype wire
